// File: src/mtgcd_pkg.sv
// ----------------------------------------------------------------------------
// mtgcd_pkg
// Shared types and constants for the missing-terms-by-GCD block.
// ----------------------------------------------------------------------------
package mtgcd_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH     = 32;
    localparam logic [FIELD_WIDTH-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] value;
        logic                   last;
    } t_in;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] missing_count;
        logic                   order_error;
    } t_out;

endpackage

// File: src/missing_terms_by_gcd_of_steps.sv
// ----------------------------------------------------------------------------
// missing_terms_by_gcd_of_steps
// Takes a strictly increasing sequence, one value per transfer with a flag on
// the last, and reports how many terms must be inserted to make it an
// arithmetic progression, plus an order error flag.
// ----------------------------------------------------------------------------
// Flow: the first value of a sequence is stored in the idle state. Each later
// value takes a difference step and, unless it is out of order, a binary GCD
// reduction on one shared subtractor/shifter. The last value of an ordered
// sequence also runs a restoring divide on the same subtractor; every last value
// then ends in a finish step that forms the result once the output register is
// free. Input ready is low while a value is being worked on; a finished result
// waits in the output register and the next value is taken meanwhile.
module missing_terms_by_gcd_of_steps #(
    parameter int VALUE_WIDTH = mtgcd_pkg::VALUE_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mtgcd_pkg::t_in   i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output mtgcd_pkg::t_out  o_data
);
    import mtgcd_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int KW = $clog2(VW + 1);
    localparam int CW = ((VW > FIELD_WIDTH) ? VW : FIELD_WIDTH) + 1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIFF   = 6'b000010,
        ST_GCD    = 6'b000100,
        ST_DSETUP = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic [VW-1:0]          r_first, n_first;
    logic [VW-1:0]          r_prev, n_prev;
    logic [VW-1:0]          r_gcd, n_gcd;
    logic [FIELD_WIDTH-1:0] r_count, n_count;
    logic                   r_err, n_err;
    logic [VW-1:0]          r_v, n_v;
    logic                   r_last, n_last;
    logic [VW-1:0]          r_a, n_a;
    logic [VW-1:0]          r_b, n_b;
    logic [VW-1:0]          r_q, n_q;
    logic [KW-1:0]          r_k, n_k;
    logic [KW-1:0]          r_bit, n_bit;
    logic                   r_out_valid, n_out_valid;
    t_out                   r_out, n_out;

    logic [63:0]            w_v64;
    logic [VW-1:0]          w_v;
    logic                   w_accept;
    logic [VW:0]            w_op_a, w_op_b;
    logic [VW+1:0]          w_sub;
    logic                   w_borrow;
    logic [FIELD_WIDTH-1:0] w_count_inc;
    logic [CW-1:0]          w_miss;
    logic [FIELD_WIDTH-1:0] w_miss_sat;

    assign w_v64    = 64'(i_data.value);
    assign w_v      = w_v64[VW-1:0];
    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    assign w_count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    // shared subtractor
    always_comb begin
        unique case (r_state)
            ST_DIFF: begin
                w_op_a = {1'b0, r_v};
                w_op_b = {1'b0, r_prev};
            end
            ST_DSETUP: begin
                w_op_a = {1'b0, r_prev};
                w_op_b = {1'b0, r_first};
            end
            ST_DIV: begin
                w_op_a = {r_a, r_q[VW-1]};
                w_op_b = {1'b0, r_b};
            end
            default: begin
                w_op_a = {1'b0, r_a};
                w_op_b = {1'b0, r_b};
            end
        endcase
    end

    assign w_sub    = {1'b0, w_op_a} - {1'b0, w_op_b};
    assign w_borrow = w_sub[VW+1];

    assign w_miss = CW'(r_q) - CW'(r_count - 1'b1);
    always_comb begin
        if (w_miss[CW-1] || r_err || (r_count <= 1)) begin
            w_miss_sat = '0;
        end else if (w_miss > CW'(COUNT_MAX)) begin
            w_miss_sat = COUNT_MAX;
        end else begin
            w_miss_sat = w_miss[FIELD_WIDTH-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_prev      = r_prev;
        n_gcd       = r_gcd;
        n_count     = r_count;
        n_err       = r_err;
        n_v         = r_v;
        n_last      = r_last;
        n_a         = r_a;
        n_b         = r_b;
        n_q         = r_q;
        n_k         = r_k;
        n_bit       = r_bit;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_v    = w_v;
                    n_last = i_data.last;
                    if (r_count == '0) begin
                        n_first = w_v;
                        n_prev  = w_v;
                        n_gcd   = '0;
                        n_err   = 1'b0;
                        n_count = w_count_inc;
                        n_state = i_data.last ? ST_FINISH : ST_IDLE;
                    end else begin
                        n_state = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                n_prev  = r_v;
                n_count = w_count_inc;
                if (w_borrow || (w_sub[VW:0] == '0)) begin
                    n_err   = 1'b1;
                    n_state = r_last ? ST_FINISH : ST_IDLE;
                end else begin
                    n_a     = r_gcd;
                    n_b     = w_sub[VW-1:0];
                    n_k     = '0;
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                if ((r_a == '0) || (r_b == '0)) begin
                    n_gcd   = (r_a == '0) ? (r_b << r_k) : (r_a << r_k);
                    if (!r_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = r_err ? ST_FINISH : ST_DSETUP;
                    end
                end else begin
                    case ({r_a[0], r_b[0]})
                        2'b00: begin
                            n_a = r_a >> 1;
                            n_b = r_b >> 1;
                            n_k = r_k + 1'b1;
                        end
                        2'b01: n_a = r_a >> 1;
                        2'b10: n_b = r_b >> 1;
                        default: begin
                            if (w_borrow) begin
                                n_a = r_b;
                                n_b = r_a;
                            end else begin
                                n_a = w_sub[VW-1:0] >> 1;
                            end
                        end
                    endcase
                end
            end
            ST_DSETUP: begin
                n_q     = w_sub[VW-1:0];
                n_a     = '0;
                n_b     = r_gcd;
                n_bit   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_borrow) begin
                    n_a = w_op_a[VW-1:0];
                    n_q = {r_q[VW-2:0], 1'b0};
                end else begin
                    n_a = w_sub[VW-1:0];
                    n_q = {r_q[VW-2:0], 1'b1};
                end
                n_bit = r_bit + 1'b1;
                if (r_bit == KW'(VW - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid           = 1'b1;
                    n_out.missing_count   = w_miss_sat;
                    n_out.order_error     = r_err;
                    n_first               = '0;
                    n_prev                = '0;
                    n_gcd                 = '0;
                    n_count               = '0;
                    n_err                 = 1'b0;
                    n_state               = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_first     <= '0;
            r_prev      <= '0;
            r_gcd       <= '0;
            r_count     <= '0;
            r_err       <= 1'b0;
            r_k         <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_prev      <= n_prev;
            r_gcd       <= n_gcd;
            r_count     <= n_count;
            r_err       <= n_err;
            r_k         <= n_k;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v    <= n_v;
        r_last <= n_last;
        r_a    <= n_a;
        r_b    <= n_b;
        r_q    <= n_q;
        r_out  <= n_out;
    end

endmodule

// File: src/mtgcd_checker.sv
// ----------------------------------------------------------------------------
// mtgcd_checker
// Port-level checks for missing_terms_by_gcd_of_steps, bound into every instance of it.
// ----------------------------------------------------------------------------
module mtgcd_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_ready,
    input mtgcd_pkg::t_in  i_data,
    input logic            o_valid,
    input logic            i_ready,
    input mtgcd_pkg::t_out o_data
);
    import mtgcd_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result changed while stalled");

    // an error result carries no count
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.order_error) |-> (o_data.missing_count == '0))
        else $error("order error with nonzero count");

    // no result appears in the cycle right after an input transfer made while no result was pending
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !o_valid) |=> !o_valid)
        else $error("result appeared too early");

    // a last value always drops input ready in the cycle after it is taken
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.last) |=> !o_ready)
        else $error("ready right after last value");

endmodule

bind missing_terms_by_gcd_of_steps mtgcd_checker u_mtgcd_checker (.*);

// File: tb/mtgcd_checker.sv
// ----------------------------------------------------------------------------
// mtgcd_tb_checker
// Watches both channels of missing_terms_by_gcd_of_steps. It folds every
// accepted value into its own copy of the sequence state, queues the expected
// result on each last value, and compares results field by field in order.
// ----------------------------------------------------------------------------
module mtgcd_tb_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  mtgcd_pkg::t_in   i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  mtgcd_pkg::t_out  i_out_data,
    output int               o_mismatches,
    output int               o_outstanding
);
    import mtgcd_pkg::*;

    logic [FIELD_WIDTH-1:0] seq_first;
    logic [FIELD_WIDTH-1:0] seq_prev;
    logic [FIELD_WIDTH-1:0] seq_gcd;
    logic [FIELD_WIDTH-1:0] seq_count;
    logic                   seq_disorder;
    t_out                   missing_q[$];
    int                     mismatch_count;

    initial begin
        seq_first      = '0;
        seq_prev       = '0;
        seq_gcd        = '0;
        seq_count      = '0;
        seq_disorder   = 1'b0;
        mismatch_count = 0;
    end

    function automatic logic [FIELD_WIDTH-1:0] step_gcd(logic [FIELD_WIDTH-1:0] a,
                                                        logic [FIELD_WIDTH-1:0] b);
        logic [FIELD_WIDTH-1:0] r;
        while (b != '0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    task automatic fold_value(t_in item);
        logic [FIELD_WIDTH-1:0] v;
        logic [FIELD_WIDTH-1:0] quotient;
        logic [FIELD_WIDTH-1:0] steps;
        t_out                   res;
        v = item.value;
        if (seq_count == '0) begin
            seq_first    = v;
            seq_gcd      = '0;
            seq_disorder = 1'b0;
        end else if (v <= seq_prev) begin
            seq_disorder = 1'b1;
        end else begin
            seq_gcd = step_gcd(seq_gcd, v - seq_prev);
        end
        seq_prev = v;
        if (seq_count != COUNT_MAX) seq_count = seq_count + 1'b1;
        if (item.last) begin
            res.missing_count = '0;
            res.order_error   = seq_disorder;
            if (!seq_disorder && seq_count > 1 && seq_gcd != '0) begin
                quotient = (seq_prev - seq_first) / seq_gcd;
                steps    = seq_count - 1'b1;
                if (quotient > steps) res.missing_count = quotient - steps;
            end
            missing_q = {missing_q, res};
            seq_first    = '0;
            seq_prev     = '0;
            seq_gcd      = '0;
            seq_count    = '0;
            seq_disorder = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (missing_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: missing_count=%0d order_error=%0b",
                                 i_out_data.missing_count, i_out_data.order_error);
                end else begin
                    want = missing_q.pop_front();
                    if (i_out_data.missing_count !== want.missing_count ||
                        i_out_data.order_error !== want.order_error) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: count exp %0d got %0d, err exp %0b got %0b",
                                     want.missing_count, i_out_data.missing_count,
                                     want.order_error, i_out_data.order_error);
                    end
                end
            end
            if (i_in_valid && i_in_ready) fold_value(i_in_data);
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= missing_q.size();
    end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression for missing_terms_by_gcd_of_steps: directed sequences for the
// edge cases, then random increasing, broken and noise sequences with random
// gaps and output stalls. Checking is done by mtgcd_tb_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import mtgcd_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 1900;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    int   mismatches;
    int   outstanding;
    int   items_sent = 0;
    int   cycles     = 0;
    int   stall_left = 0;
    bit   in_calm    = 1'b0;
    bit   out_calm   = 1'b0;

    missing_terms_by_gcd_of_steps dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_data)
    );

    mtgcd_tb_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("missing_terms_by_gcd_of_steps regression: fail");
            $finish;
        end
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (!out_calm && $urandom_range(0, 99) < 20) stall_left <= idle_length();
        end
        if ($urandom_range(0, 299) == 0) out_calm <= !out_calm;
    end

    task automatic send_value(logic [FIELD_WIDTH-1:0] v, logic l);
        int gap;
        if (!in_calm && $urandom_range(0, 99) < 30) begin
            gap = idle_length();
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_data.value <= v;
        in_data.last  <= l;
        in_valid      <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        items_sent++;
        if ($urandom_range(0, 199) == 0) in_calm = !in_calm;
    endtask

    task automatic random_sequence();
        int                     kind;
        int                     len;
        int                     bad_at;
        int                     gbits;
        int                     i;
        logic [63:0]            mask;
        logic [FIELD_WIDTH-1:0] g;
        logic [FIELD_WIDTH-1:0] v;
        kind = $urandom_range(0, 99);
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        if (kind < 8) begin
            for (i = 0; i < len; i++) send_value($urandom, $urandom_range(0, 2) == 0);
        end else begin
            bad_at = len + 1;
            if (kind < 20) begin
                if (len < 2) len = 2;
                bad_at = $urandom_range(1, len - 1);
            end
            gbits = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 16) : $urandom_range(17, 31);
            mask  = (64'd1 << gbits) - 1;
            g     = $urandom & mask[FIELD_WIDTH-1:0];
            if (g == '0) g = 1;
            v = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000);
            for (i = 0; i < len; i++) begin
                if (i == bad_at)
                    v = $urandom_range(0, 1) ? v : v - $urandom_range(1, 1000);
                else if (i > 0)
                    v = v + $urandom_range(1, 12) * g;
                send_value(v, i == len - 1);
            end
        end
    endtask

    initial begin
        int target;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-value sequences at both extremes
        send_value(32'h0000_0000, 1'b1);
        send_value(32'hFFFF_FFFF, 1'b1);
        // widest single step
        send_value(32'h0000_0000, 1'b0);
        send_value(32'hFFFF_FFFF, 1'b1);
        // step of one across the whole range
        send_value(32'h0000_0000, 1'b0);
        send_value(32'h0000_0001, 1'b0);
        send_value(32'hFFFF_FFFF, 1'b1);
        // repeated value
        send_value(32'd5, 1'b0);
        send_value(32'd5, 1'b1);
        // drop in the middle
        send_value(32'd10, 1'b0);
        send_value(32'd4, 1'b0);
        send_value(32'd20, 1'b1);
        // gcd 3 with gaps
        send_value(32'd3, 1'b0);
        send_value(32'd9, 1'b0);
        send_value(32'd12, 1'b0);
        send_value(32'd21, 1'b1);
        // already a progression
        send_value(32'd100, 1'b0);
        send_value(32'd110, 1'b0);
        send_value(32'd120, 1'b1);
        // drop on the last value
        send_value(32'h5555_5555, 1'b0);
        send_value(32'hAAAA_AAAA, 1'b0);
        send_value(32'h5555_5555, 1'b1);

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) random_sequence();
        in_valid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("missing_terms_by_gcd_of_steps regression: pass");
        else
            $display("missing_terms_by_gcd_of_steps regression: fail");
        $finish;
    end

endmodule
